[hw/rtl/psev_pkg.sv]
package psev_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int VALUE_WIDTH = 32;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_OPER,
        CMD_END
    } cmd_kind_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_BAD
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FEW       = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    typedef struct packed {
        cmd_kind_t              kind;
        op_t                    op;
        logic [VALUE_WIDTH-1:0] value;
    } cmd_t;

endpackage

[hw/rtl/postfix_stack_evaluator.sv]
// channel  dir  ports                                        meaning
// s_       in   s_req_type, s_number_value, s_operator_char  one token
// m_       out  m_final_value, m_status                      one result per end token
//
// a number or end token is handled in the execute side's idle state, an operator
// goes through a stack memory read, then the alu, and a division then through the
// bit-serial divider; the token queue registers each token up front
// reset is synchronous, active low; the stack needs no clearing pass
// the token queue keeps taking transactions until full while the execute side or the
// result register stalls; an end token waits until the result register is free
module postfix_stack_evaluator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_number_value,
    input  logic [7:0]         s_operator_char,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_final_value,
    output logic [2:0]         m_status
);
    import psev_pkg::*;

    logic q_full;
    logic q_wr;
    logic q_rd;
    logic q_valid;
    cmd_t wr_cmd;
    cmd_t rd_cmd;

    psev_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_number_value  (s_number_value),
        .s_operator_char (s_operator_char),
        .q_full          (q_full),
        .q_wr            (q_wr),
        .q_cmd           (wr_cmd)
    );

    psev_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_cmd   (wr_cmd),
        .full     (q_full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_cmd   (rd_cmd)
    );

    psev_exec u_exec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (rd_cmd),
        .q_rd          (q_rd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_final_value (m_final_value),
        .m_status      (m_status)
    );

endmodule

[hw/rtl/psev_front.sv]
module psev_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [31:0] s_number_value,
    input  logic [7:0]         s_operator_char,
    input  logic               q_full,
    output logic               q_wr,
    output psev_pkg::cmd_t     q_cmd
);
    import psev_pkg::*;

    typedef enum logic [1:0] {
        REQ_NUMBER,
        REQ_OPERATOR,
        REQ_END,
        REQ_UNUSED
    } req_t;

    req_t                        req;
    logic [VALUE_WIDTH+31:0]     num_ext;

    assign req     = req_t'(s_req_type);
    assign num_ext = {{VALUE_WIDTH{s_number_value[31]}}, s_number_value};
    assign s_ready = !q_full;

    // unused request type is taken and dropped here
    assign q_wr = s_valid && !q_full && (req != REQ_UNUSED);

    always_comb begin
        q_cmd.value = num_ext[VALUE_WIDTH-1:0];
        unique case (req)
            REQ_NUMBER:   q_cmd.kind = CMD_PUSH;
            REQ_OPERATOR: q_cmd.kind = CMD_OPER;
            REQ_END:      q_cmd.kind = CMD_END;
            REQ_UNUSED:   q_cmd.kind = CMD_END;
        endcase
        unique case (s_operator_char)
            CH_PLUS:  q_cmd.op = OP_ADD;
            CH_MINUS: q_cmd.op = OP_SUB;
            CH_STAR:  q_cmd.op = OP_MUL;
            CH_SLASH: q_cmd.op = OP_DIV;
            default:  q_cmd.op = OP_BAD;
        endcase
    end

endmodule

[hw/rtl/psev_queue.sv]
module psev_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  psev_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output psev_pkg::cmd_t rd_cmd
);
    import psev_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                slot_reg[wr_ptr_reg] <= wr_cmd;
                wr_ptr_reg           <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hw/rtl/psev_div.sv]
module psev_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [psev_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [psev_pkg::VALUE_WIDTH-1:0] divisor,
    output logic                             done,
    output logic [psev_pkg::VALUE_WIDTH-1:0] quotient
);
    import psev_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int DCNT_W = $clog2(W + 1);

    logic [W-1:0]      rem_reg;
    logic [W-1:0]      quo_reg;
    logic [W-1:0]      dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = !diff[W];

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= DCNT_W'(W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/psev_exec.sv]
module psev_exec (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  psev_pkg::cmd_t     q_cmd,
    output logic               q_rd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_final_value,
    output logic [2:0]         m_status
);
    import psev_pkg::*;

    localparam int W = VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    status_t            err_reg;
    op_t                op_reg;
    logic               neg_reg;
    logic [W-1:0]       top_reg;
    logic [W-1:0]       rd_data_reg;
    logic [W-1:0]       mem [STACK_DEPTH];
    logic               out_valid_reg;
    logic [31:0]        out_value_reg;
    status_t            out_status_reg;

    logic               out_free;
    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   count_m2;
    logic [W-1:0]       lhs;
    logic [W-1:0]       rhs;
    logic [W-1:0]       sum;
    logic [W-1:0]       dif;
    logic [W-1:0]       prod;
    logic [W-1:0]       lhs_mag;
    logic [W-1:0]       rhs_mag;
    logic [W+31:0]      top_ext;
    logic               div_start;
    logic               div_done;
    logic [W-1:0]       div_quo;

    assign out_free = !out_valid_reg || m_ready;
    assign q_rd     = q_valid && (state_reg == S_IDLE) && ((q_cmd.kind != CMD_END) || out_free);

    assign count_m1 = count_reg - 1'b1;
    assign count_m2 = count_reg - 2'd2;

    // top of stack lives in top_reg, the entries below it in mem
    assign lhs     = rd_data_reg;
    assign rhs     = top_reg;
    assign sum     = lhs + rhs;
    assign dif     = lhs - rhs;
    assign prod    = lhs * rhs;
    assign lhs_mag = lhs[W-1] ? (~lhs + 1'b1) : lhs;
    assign rhs_mag = rhs[W-1] ? (~rhs + 1'b1) : rhs;
    assign top_ext = {{32{top_reg[W-1]}}, top_reg};

    assign div_start = (state_reg == S_EXEC) && (op_reg == OP_DIV) && (rhs != '0);

    psev_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lhs_mag),
        .divisor  (rhs_mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_valid       = out_valid_reg;
    assign m_final_value = out_value_reg;
    assign m_status      = out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_rd) begin
                        unique case (q_cmd.kind)
                            CMD_PUSH: begin
                                if (err_reg == ST_OK && count_reg != CNT_W'(STACK_DEPTH)) begin
                                    if (count_reg != '0) begin
                                        mem[count_m1[ADDR_W-1:0]] <= top_reg;
                                    end
                                    top_reg   <= q_cmd.value;
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            CMD_OPER: begin
                                if (err_reg == ST_OK) begin
                                    if (count_reg < CNT_W'(2)) begin
                                        err_reg <= ST_FEW;
                                    end else begin
                                        rd_data_reg <= mem[count_m2[ADDR_W-1:0]];
                                        op_reg      <= q_cmd.op;
                                        state_reg   <= S_EXEC;
                                    end
                                end
                            end
                            CMD_END: begin
                                out_valid_reg <= 1'b1;
                                if (err_reg != ST_OK) begin
                                    out_value_reg  <= '1;
                                    out_status_reg <= err_reg;
                                end else if (count_reg != CNT_W'(1)) begin
                                    out_value_reg  <= '1;
                                    out_status_reg <= ST_MALFORMED;
                                end else begin
                                    out_value_reg  <= top_ext[31:0];
                                    out_status_reg <= ST_OK;
                                end
                                count_reg <= '0;
                                err_reg   <= ST_OK;
                            end
                            default: begin
                                count_reg <= count_reg;
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    state_reg <= S_IDLE;
                    unique case (op_reg)
                        OP_ADD: begin
                            top_reg   <= sum;
                            count_reg <= count_m1;
                        end
                        OP_SUB: begin
                            top_reg   <= dif;
                            count_reg <= count_m1;
                        end
                        OP_MUL: begin
                            top_reg   <= prod;
                            count_reg <= count_m1;
                        end
                        OP_DIV: begin
                            if (rhs == '0) begin
                                err_reg   <= ST_DIVZERO;
                                count_reg <= count_m2;
                            end else begin
                                neg_reg   <= lhs[W-1] ^ rhs[W-1];
                                state_reg <= S_DIV;
                            end
                        end
                        default: begin
                            err_reg   <= ST_UNKNOWN;
                            count_reg <= count_m2;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        top_reg   <= neg_reg ? (~div_quo + 1'b1) : div_quo;
                        count_reg <= count_m1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
